// ===== rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, command codes and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_DAYS   = 2'd1;
  localparam logic [1:0] ACT_MONTHS = 2'd2;
  localparam logic [1:0] ACT_YEARS  = 2'd3;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [8:0]  QUAD_CENT = 9'd400;
  localparam logic [8:0]  CENT      = 9'd100;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [4:0]  FEB_LEAP  = 5'd29;
  localparam logic [4:0]  FEB_COMMON = 5'd28;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] amount;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
  } cda_in_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic        overflow;
  } cda_out_t;

  // Leap test from the year modulo 400.
  function automatic logic is_leap(input logic [8:0] ymod);
    logic cent_hit;
    cent_hit = (ymod == CENT) || (ymod == 9'(2 * CENT)) || (ymod == 9'(3 * CENT));
    return (ymod == 9'd0) || ((ymod[1:0] == 2'b00) && !cent_hit);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? FEB_LEAP : FEB_COMMON;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_adder_core.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder_core
// Holds one Gregorian date and applies one command per transfer, stepping
// days and months through a small sequencer with a shared year-mod-400 unit.
// ----------------------------------------------------------------------------
// Sequence: set date and add years run S_MOD, S_REM, S_CLAMP, then S_DONE
//   (reciprocal quotient by 400, remainder on the year, then day clamp).
// Add days repeats S_DAYS per day; add months repeats S_MONTHS and S_MCLAMP.
// One command at a time; in_stall is high until the result is registered.
// Reset: date 1 January 0000, no result pending.
`default_nettype none

module calendar_date_adder_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cda_pkg::cda_in_t    in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output cda_pkg::cda_out_t   out_data
);
  import cda_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DAYS   = 3'd1;
  localparam logic [2:0] S_MONTHS = 3'd2;
  localparam logic [2:0] S_MCLAMP = 3'd3;
  localparam logic [2:0] S_MOD    = 3'd4;
  localparam logic [2:0] S_CLAMP  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;
  localparam logic [2:0] S_REM    = 3'd7;

  // round(2^21 / 400); exact quotient for every year up to 9999
  localparam logic [12:0] QUAD_CENT_RECIP = 13'd5243;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [8:0]  ymod_r, ymod_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [4:0]  quo_r, quo_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  cda_out_t    out_r, out_nxt;

  logic        accept;
  logic        out_free;
  logic [4:0]  cur_len;
  logic [25:0] quo_prod;
  logic [13:0] rem_calc;
  logic [16:0] year_sum;
  logic [8:0]  ymod_inc;
  logic [3:0]  ld_month;
  logic [4:0]  ld_day;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur_len  = month_len(month_r, is_leap(ymod_r));
  assign quo_prod = 26'(year_r) * 26'(QUAD_CENT_RECIP);
  assign rem_calc = year_r - 14'(quo_r) * 14'(QUAD_CENT);
  assign year_sum = {3'b000, year_r} + {1'b0, in_data.amount};
  assign ymod_inc = (ymod_r == 9'(QUAD_CENT - 9'd1)) ? 9'd0 : ymod_r + 9'd1;

  always_comb begin
    ld_month = in_data.new_month;
    if (ld_month == 4'd0) ld_month = 4'd1;
    if (ld_month > MONTH_DEC) ld_month = MONTH_DEC;
    ld_day = (in_data.new_day == 5'd0) ? 5'd1 : in_data.new_day;
  end

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    ymod_nxt      = ymod_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ovf_nxt = 1'b0;
          cnt_nxt = in_data.amount;
          case (in_data.action)
            ACT_SET: begin
              day_nxt   = ld_day;
              month_nxt = ld_month;
              if (in_data.new_year > YEAR_MAX) begin
                year_nxt = YEAR_MAX;
                ovf_nxt  = 1'b1;
              end else begin
                year_nxt = in_data.new_year;
              end
              state_nxt = S_MOD;
            end
            ACT_DAYS: begin
              state_nxt = (in_data.amount == 16'd0) ? S_DONE : S_DAYS;
            end
            ACT_MONTHS: begin
              state_nxt = (in_data.amount == 16'd0) ? S_DONE : S_MONTHS;
            end
            default: begin
              if (year_sum > {3'b000, YEAR_MAX}) begin
                year_nxt = YEAR_MAX;
                ovf_nxt  = 1'b1;
              end else begin
                year_nxt = year_sum[13:0];
              end
              state_nxt = S_MOD;
            end
          endcase
        end
      end
      S_DAYS: begin
        cnt_nxt   = cnt_r - 16'd1;
        state_nxt = (cnt_r == 16'd1) ? S_DONE : S_DAYS;
        if (day_r < cur_len) begin
          day_nxt = day_r + 5'd1;
        end else if (month_r < MONTH_DEC) begin
          month_nxt = month_r + 4'd1;
          day_nxt   = 5'd1;
        end else if (year_r < YEAR_MAX) begin
          year_nxt  = year_r + 14'd1;
          ymod_nxt  = ymod_inc;
          month_nxt = 4'd1;
          day_nxt   = 5'd1;
        end else begin
          // drop the remaining steps
          ovf_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_MONTHS: begin
        state_nxt = S_MCLAMP;
        if (month_r < MONTH_DEC) begin
          month_nxt = month_r + 4'd1;
        end else if (year_r < YEAR_MAX) begin
          year_nxt  = year_r + 14'd1;
          ymod_nxt  = ymod_inc;
          month_nxt = 4'd1;
        end else begin
          ovf_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_MCLAMP: begin
        if (day_r > cur_len) day_nxt = cur_len;
        cnt_nxt   = cnt_r - 16'd1;
        state_nxt = (cnt_r == 16'd1) ? S_DONE : S_MONTHS;
      end
      S_MOD: begin
        // quotient by 400 through the reciprocal product
        quo_nxt   = 5'(quo_prod >> 21);
        state_nxt = S_REM;
      end
      S_REM: begin
        ymod_nxt  = 9'(rem_calc);
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        if (day_r > cur_len) day_nxt = cur_len;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_nxt.day_out   = day_r;
          out_nxt.month_out = month_r;
          out_nxt.year_out  = year_r;
          out_nxt.overflow  = ovf_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= 14'd0;
      ymod_r      <= 9'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      ymod_r      <= ymod_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/cda_checker.sv =====
// ----------------------------------------------------------------------------
// cda_checker
// Port-level assertions for the date adder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input cda_pkg::cda_in_t   in_data,
  input wire                out_valid,
  input wire                out_stall,
  input cda_pkg::cda_out_t  out_data
);
  import cda_pkg::*;

  // one command at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after input transfer");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled command changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.month_out >= 4'd1 && out_data.month_out <= MONTH_DEC &&
                   out_data.day_out >= 5'd1 && out_data.year_out <= YEAR_MAX))
    else $error("result date out of range");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.month_out == MONTH_FEB) |-> (out_data.day_out <= FEB_LEAP))
    else $error("february day beyond 29");

endmodule

bind calendar_date_adder_core cda_checker u_cda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
